FILE: rtl/rtdb_pkg.sv
// Shared types and constants for the radix text-to-byte decoder.
// Holds the character codes, radix codes and the digit decode function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtdb_pkg;

  localparam int CHAR_W = 8;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int PART_W = 7;
  localparam int COUNT_W = 3;
  localparam int DIGIT_W = 4;

  typedef enum logic [1:0] {
    RADIX_HEX = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OFF = 2'd3
  } radix_t;

  typedef enum logic [0:0] {
    REG_RADIX_MODE    = 1'b0,
    REG_START_ADDRESS = 1'b1
  } reg_index_t;

  // Position of the last digit of a group for each radix.
  localparam logic [COUNT_W-1:0] LAST_HEX = 3'd1;
  localparam logic [COUNT_W-1:0] LAST_OCT = 3'd2;
  localparam logic [COUNT_W-1:0] LAST_BIN = 3'd7;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd48;
  localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'd87;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET = 8'd55;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] value;
  } digit_t;

  function automatic digit_t digit_decode(radix_t mode, logic [CHAR_W-1:0] c);
    digit_t d;
    d.valid = 1'b0;
    d.value = '0;
    unique case (mode)
      RADIX_HEX: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          d.valid = 1'b1;
          d.value = DIGIT_W'(c - DIGIT_OFFSET);
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
          d.valid = 1'b1;
          d.value = DIGIT_W'(c - LOWER_OFFSET);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
          d.valid = 1'b1;
          d.value = DIGIT_W'(c - UPPER_OFFSET);
        end
      end
      RADIX_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          d.valid = 1'b1;
          d.value = DIGIT_W'(c - DIGIT_OFFSET);
        end
      end
      RADIX_BIN: begin
        if (c == CH_ZERO || c == CH_ONE) begin
          d.valid = 1'b1;
          d.value = DIGIT_W'(c - DIGIT_OFFSET);
        end
      end
      RADIX_OFF: begin
        d.valid = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rtdb_if.sv
// Request channels of the radix text-to-byte decoder: the character input
// channel and the byte result channel. Depends on rtdb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rtdb_in_if import rtdb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              file_start;
  logic              pass_start;
  logic              emit;

  modport source (output valid, char_code, file_start, pass_start, emit, input ready);
  modport sink (input valid, char_code, file_start, pass_start, emit, output ready);
endinterface

interface rtdb_out_if import rtdb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic [ADDR_W-1:0] byte_address;

  modport source (output valid, byte_value, byte_address, input ready);
  modport sink (input valid, byte_value, byte_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/radix_text_to_byte_decoder_top.sv
// Radix text-to-byte decoder: input register, decode logic and result register.
// Depends on rtdb_pkg and the channel interfaces in rtdb_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one text character per cycle and returns one result per
// completed byte when emit is set. A request is captured in an input
// register; the decode logic then updates the digit, comment and address
// state from it and loads the result register, which drives the output.
// The input register is freed every cycle unless it holds a byte-completing
// character with emit set while the result register still waits for the
// sink, so with a ready sink the rate is one character per cycle.
// Configuration writes (radix and start address) take effect at once and
// belong between streams.
module radix_text_to_byte_decoder_top import rtdb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire reg_index_t        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  rtdb_in_if.sink                in_ch,
  rtdb_out_if.source             out_ch
);

  radix_t              radix_mode;
  logic [ADDR_W-1:0]   start_address;

  logic                in_full;
  logic [CHAR_W-1:0]   in_char;
  logic                in_file_start;
  logic                in_pass_start;
  logic                in_emit;

  logic [PART_W-1:0]   partial_value, partial_value_next;
  logic [COUNT_W-1:0]  digit_count, digit_count_next;
  logic                in_comment, in_comment_next;
  logic [ADDR_W-1:0]   byte_counter, byte_counter_next;

  logic                out_valid, out_valid_next;
  logic [BYTE_W-1:0]   out_value;
  logic [ADDR_W-1:0]   out_address;

  logic [PART_W-1:0]   pv0;
  logic [COUNT_W-1:0]  dc0;
  logic                ic0;
  logic [ADDR_W-1:0]   bc0;
  digit_t              dig;
  logic [COUNT_W-1:0]  last;
  logic [10:0]         group;
  logic                produce;
  logic                advance;

  always_comb begin
    pv0 = in_file_start ? '0 : partial_value;
    dc0 = in_file_start ? '0 : digit_count;
    ic0 = in_file_start ? 1'b0 : in_comment;
    bc0 = in_pass_start ? start_address : byte_counter;
    dig = digit_decode(radix_mode, in_char);

    unique case (radix_mode)
      RADIX_HEX: begin
        last  = LAST_HEX;
        group = {pv0, dig.value};
      end
      RADIX_OCT: begin
        last  = LAST_OCT;
        group = {1'b0, pv0, dig.value[2:0]};
      end
      RADIX_BIN: begin
        last  = LAST_BIN;
        group = {3'b000, pv0, dig.value[0]};
      end
      RADIX_OFF: begin
        last  = LAST_BIN;
        group = '0;
      end
    endcase

    partial_value_next = pv0;
    digit_count_next   = dc0;
    in_comment_next    = ic0;
    byte_counter_next  = bc0;
    produce            = 1'b0;

    // An unused radix leaves everything but the start flags alone.
    if (radix_mode != RADIX_OFF) begin
      if (ic0) begin
        if (in_char == CH_LF || in_char == CH_CR) begin
          in_comment_next = 1'b0;
        end
      end else if (in_char == CH_HASH || in_char == CH_SEMI) begin
        in_comment_next = 1'b1;
      end else if (dig.valid) begin
        if (dc0 >= last) begin
          partial_value_next = '0;
          digit_count_next   = '0;
          byte_counter_next  = bc0 + ADDR_W'(1);
          produce            = in_emit;
        end else begin
          partial_value_next = (dc0 == '0) ? PART_W'(dig.value) : group[PART_W-1:0];
          digit_count_next   = dc0 + COUNT_W'(1);
        end
      end
    end
  end

  assign advance      = in_full && (!produce || !out_valid || out_ch.ready);
  assign in_ch.ready  = !in_full || advance;

  always_comb begin
    if (advance && produce) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode    <= RADIX_HEX;
      start_address <= '0;
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      partial_value <= '0;
      digit_count   <= '0;
      in_comment    <= 1'b0;
      byte_counter  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIX_MODE:    radix_mode    <= radix_t'(cfg_data[1:0]);
          REG_START_ADDRESS: start_address <= cfg_data[ADDR_W-1:0];
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        partial_value <= partial_value_next;
        digit_count   <= digit_count_next;
        in_comment    <= in_comment_next;
        byte_counter  <= byte_counter_next;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char       <= in_ch.char_code;
      in_file_start <= in_ch.file_start;
      in_pass_start <= in_ch.pass_start;
      in_emit       <= in_ch.emit;
    end
    if (advance && produce) begin
      out_value   <= group[BYTE_W-1:0];
      out_address <= bc0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.byte_value   = out_value;
  assign out_ch.byte_address = out_address;

endmodule

`default_nettype wire

FILE: rtl/rtdb_checker.sv
// Port-level checks for the radix text-to-byte decoder and the bind that
// attaches them to radix_text_to_byte_decoder_top. Depends on rtdb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtdb_checker import rtdb_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte_value,
  input wire logic [ADDR_W-1:0] out_byte_address
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte_value) && $stable(out_byte_address))
    else $error("result payload changed while stalled");

  // With a ready sink the decoder never holds back the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although the result side is ready");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("decoder not empty after reset");

endmodule

bind radix_text_to_byte_decoder_top rtdb_checker u_rtdb_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte_value   (out_ch.byte_value),
  .out_byte_address (out_ch.byte_address)
);

`default_nettype wire
